>>> design/ips_pkg.sv
// shared types, widths and constants for the inverse park / svpwm pipeline
// no dependencies
package ips_pkg;

  // port field widths
  localparam int IN_W      = 16;
  localparam int AB_W      = 17;
  localparam int CMP_W     = 16;
  localparam int CFG_W     = 16;
  localparam int CFG_IDX_W = 1;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_SUPPLY = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_PERIOD = 1'd1;

  localparam logic [CFG_W-1:0] SUPPLY_RESET = 16'd12288;
  localparam logic [CFG_W-1:0] PERIOD_RESET = 16'd4200;
  localparam logic [CFG_W-1:0] PERIOD_GUARD = 16'd5;

  // internal widths
  localparam int PROD_W = 2 * IN_W;        // rotation products
  localparam int RSUM_W = PROD_W + 1;      // rotation sums
  localparam int RND_SH = 14;              // sine/cosine fraction bits
  localparam int KM_W   = 36;              // constant-scaled alpha/beta
  localparam int T_W    = 37;              // active vector times
  localparam int S_W    = 38;              // time sums and divisor
  localparam int N_W    = 40;              // compare numerators
  localparam int P_W    = N_W + CFG_W + 1; // period times numerator
  localparam int DIV_W  = 58;              // divider dividend / remainder
  localparam int Q_W    = 18;              // quotient incl. overflow bits
  localparam int DIV_STAGES = Q_W;

  // fixed-point constants, scaled by 2^16
  localparam logic signed [KM_W-1:0] K_SQRT3      = 36'sd113512;
  localparam logic signed [KM_W-1:0] K_HALF_SQRT3 = 36'sd56756;
  localparam logic signed [KM_W-1:0] K_ONE_HALF   = 36'sd98304;
  localparam int SUPPLY_SH = 16;

  // sector codes
  localparam logic [2:0] SEC_ZERO = 3'd0;
  localparam logic [2:0] SEC_1    = 3'd1;
  localparam logic [2:0] SEC_2    = 3'd2;
  localparam logic [2:0] SEC_3    = 3'd3;
  localparam logic [2:0] SEC_4    = 3'd4;
  localparam logic [2:0] SEC_5    = 3'd5;
  localparam logic [2:0] SEC_6    = 3'd6;

  // per-beat sideband carried alongside the compare math
  typedef struct packed {
    logic                   valid;
    logic [2:0]             sector;
    logic signed [AB_W-1:0] alpha;
    logic signed [AB_W-1:0] beta;
  } ips_side_t;

endpackage

>>> design/inverse_park_svpwm.sv
// Inverse park transform and space vector pwm compare generation.
// An item is taken in every cycle while busy is low (busy is always low) and its
// result appears with out_valid after rotation, sector and numerator math, the period
// multiply and rounding add, the pipelined divider that yields one quotient bit per
// stage, and the output register. Results cannot be
// stalled; one result leaves per accepted beat. Configuration is written directly
// and is read live by the pipeline, so write it only when no beat is in flight.
// depends on ips_pkg, ips_park, ips_sector, ips_div
module inverse_park_svpwm (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            start,
  output logic                            busy,
  input  logic signed [ips_pkg::IN_W-1:0] in_volt_q,
  input  logic signed [ips_pkg::IN_W-1:0] in_volt_d,
  input  logic signed [ips_pkg::IN_W-1:0] in_sin_angle,
  input  logic signed [ips_pkg::IN_W-1:0] in_cos_angle,
  input  logic                            cfg_wr_en,
  input  logic [ips_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [ips_pkg::CFG_W-1:0]       cfg_wdata,
  output logic                            out_valid,
  output logic signed [ips_pkg::AB_W-1:0] out_volt_alpha,
  output logic signed [ips_pkg::AB_W-1:0] out_volt_beta,
  output logic [ips_pkg::CMP_W-1:0]       out_compare_a,
  output logic [ips_pkg::CMP_W-1:0]       out_compare_b,
  output logic [ips_pkg::CMP_W-1:0]       out_compare_c
);
  import ips_pkg::*;

  localparam int SB_DEPTH = 2 + DIV_STAGES;

  logic [CFG_W-1:0] supply_r, period_r;
  logic             park_valid;
  logic signed [AB_W-1:0] park_alpha, park_beta;
  ips_side_t        sec_side;
  logic signed [S_W-1:0]  sec_den;
  logic signed [N_W-1:0]  sec_n0, sec_nb, sec_nc;

  logic signed [P_W-1:0]  p0_r, pb_r, pc_r;
  logic signed [S_W-1:0]  den8_r;
  logic [DIV_W-1:0]       num0_r, numb_r, numc_r, dvs9_r;
  logic [Q_W-1:0]         q0, qb, qc;
  ips_side_t              sb_r [SB_DEPTH];
  ips_side_t              side_end;

  logic [CFG_W-1:0]       limit_nxt, v0_nxt, vb_nxt, vc_nxt;
  logic [CMP_W-1:0]       ca_nxt, cb_nxt, cc_nxt;
  logic [CMP_W-1:0]       ca_r, cb_r, cc_r;
  logic signed [AB_W-1:0] alpha_r, beta_r;
  logic                   valid_r;

  assign busy = 1'b0;

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      supply_r <= SUPPLY_RESET;
      period_r <= PERIOD_RESET;
    end else if (cfg_wr_en) begin
      unique case (cfg_index)
        REG_SUPPLY: supply_r <= cfg_wdata;
        REG_PERIOD: period_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  ips_park u_park (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (start),
    .volt_q    (in_volt_q),
    .volt_d    (in_volt_d),
    .sin_angle (in_sin_angle),
    .cos_angle (in_cos_angle),
    .out_valid (park_valid),
    .alpha     (park_alpha),
    .beta      (park_beta)
  );

  ips_sector u_sector (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (park_valid),
    .alpha    (park_alpha),
    .beta     (park_beta),
    .supply   (supply_r),
    .side     (sec_side),
    .den      (sec_den),
    .num_0    (sec_n0),
    .num_b    (sec_nb),
    .num_c    (sec_nc)
  );

  // stage 8: period times numerator
  always_ff @(posedge clk) begin
    p0_r   <= P_W'($signed({1'b0, period_r})) * P_W'(sec_n0);
    pb_r   <= P_W'($signed({1'b0, period_r})) * P_W'(sec_nb);
    pc_r   <= P_W'($signed({1'b0, period_r})) * P_W'(sec_nc);
    den8_r <= sec_den;
  end

  // stage 9: add half divisor for rounding; negative numerators give zero
  always_ff @(posedge clk) begin
    num0_r <= (p0_r < 0) ? '0 : DIV_W'(p0_r) + (DIV_W'(den8_r) << 1);
    numb_r <= (pb_r < 0) ? '0 : DIV_W'(pb_r) + (DIV_W'(den8_r) << 1);
    numc_r <= (pc_r < 0) ? '0 : DIV_W'(pc_r) + (DIV_W'(den8_r) << 1);
    dvs9_r <= DIV_W'(den8_r) << 2;
  end

  ips_div u_div_0 (.clk(clk), .dividend(num0_r), .divisor(dvs9_r), .quotient(q0));
  ips_div u_div_b (.clk(clk), .dividend(numb_r), .divisor(dvs9_r), .quotient(qb));
  ips_div u_div_c (.clk(clk), .dividend(numc_r), .divisor(dvs9_r), .quotient(qc));

  // sideband delay line matching the multiply, add and divider stages
  always_ff @(posedge clk) begin
    for (int i = 0; i < SB_DEPTH; i++) begin
      if (!rst_n) sb_r[i].valid <= 1'b0;
      else if (i == 0) sb_r[i] <= sec_side;
      else sb_r[i] <= sb_r[i-1];
    end
  end

  assign side_end = sb_r[SB_DEPTH-1];

  // clamp to period minus guard, zero vector, phase routing
  always_comb begin
    limit_nxt = (period_r >= PERIOD_GUARD) ? (period_r - PERIOD_GUARD) : '0;
    v0_nxt = (q0 > Q_W'(limit_nxt)) ? limit_nxt : CFG_W'(q0);
    vb_nxt = (qb > Q_W'(limit_nxt)) ? limit_nxt : CFG_W'(qb);
    vc_nxt = (qc > Q_W'(limit_nxt)) ? limit_nxt : CFG_W'(qc);
    unique case (side_end.sector)
      SEC_1: begin ca_nxt = vb_nxt; cb_nxt = v0_nxt; cc_nxt = vc_nxt; end
      SEC_2: begin ca_nxt = v0_nxt; cb_nxt = vc_nxt; cc_nxt = vb_nxt; end
      SEC_3: begin ca_nxt = v0_nxt; cb_nxt = vb_nxt; cc_nxt = vc_nxt; end
      SEC_4: begin ca_nxt = vc_nxt; cb_nxt = vb_nxt; cc_nxt = v0_nxt; end
      SEC_5: begin ca_nxt = vc_nxt; cb_nxt = v0_nxt; cc_nxt = vb_nxt; end
      SEC_6: begin ca_nxt = vb_nxt; cb_nxt = vc_nxt; cc_nxt = v0_nxt; end
      default: begin ca_nxt = '0; cb_nxt = '0; cc_nxt = '0; end
    endcase
  end

  // output register
  always_ff @(posedge clk) begin
    ca_r    <= ca_nxt;
    cb_r    <= cb_nxt;
    cc_r    <= cc_nxt;
    alpha_r <= side_end.alpha;
    beta_r  <= side_end.beta;
    if (!rst_n) valid_r <= 1'b0;
    else valid_r <= side_end.valid;
  end

  assign out_valid      = valid_r;
  assign out_volt_alpha = alpha_r;
  assign out_volt_beta  = beta_r;
  assign out_compare_a  = ca_r;
  assign out_compare_b  = cb_r;
  assign out_compare_c  = cc_r;

endmodule

>>> design/ips_park.sv
// inverse park rotation: two stages (products, round and saturate)
// depends on ips_pkg
module ips_park (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  input  logic signed [ips_pkg::IN_W-1:0] volt_q,
  input  logic signed [ips_pkg::IN_W-1:0] volt_d,
  input  logic signed [ips_pkg::IN_W-1:0] sin_angle,
  input  logic signed [ips_pkg::IN_W-1:0] cos_angle,
  output logic                           out_valid,
  output logic signed [ips_pkg::AB_W-1:0] alpha,
  output logic signed [ips_pkg::AB_W-1:0] beta
);
  import ips_pkg::*;

  localparam int QR_W = RSUM_W - RND_SH;
  localparam logic signed [RSUM_W-1:0] RND_HALF = RSUM_W'(1 << (RND_SH - 1));
  localparam logic signed [QR_W-1:0] AB_MAX = QR_W'((1 << (AB_W - 1)) - 1);
  localparam logic signed [QR_W-1:0] AB_MIN = -QR_W'(1 << (AB_W - 1));

  logic                     v1_r, v2_r;
  logic signed [PROD_W-1:0] p_dc_r, p_qs_r, p_ds_r, p_qc_r;
  logic signed [RSUM_W-1:0] sa_nxt, sb_nxt;
  logic signed [QR_W-1:0]   qa_nxt, qb_nxt;
  logic signed [AB_W-1:0]   alpha_r, beta_r, alpha_nxt, beta_nxt;

  // stage 1: four products
  always_ff @(posedge clk) begin
    p_dc_r <= volt_d * cos_angle;
    p_qs_r <= volt_q * sin_angle;
    p_ds_r <= volt_d * sin_angle;
    p_qc_r <= volt_q * cos_angle;
  end

  // stage 2: sum, round half up, saturate
  always_comb begin
    sa_nxt = RSUM_W'(p_dc_r) - RSUM_W'(p_qs_r) + RND_HALF;
    sb_nxt = RSUM_W'(p_ds_r) + RSUM_W'(p_qc_r) + RND_HALF;
    qa_nxt = QR_W'(sa_nxt >>> RND_SH);
    qb_nxt = QR_W'(sb_nxt >>> RND_SH);
    if (qa_nxt > AB_MAX) alpha_nxt = AB_W'(AB_MAX);
    else if (qa_nxt < AB_MIN) alpha_nxt = AB_W'(AB_MIN);
    else alpha_nxt = AB_W'(qa_nxt);
    if (qb_nxt > AB_MAX) beta_nxt = AB_W'(AB_MAX);
    else if (qb_nxt < AB_MIN) beta_nxt = AB_W'(AB_MIN);
    else beta_nxt = AB_W'(qb_nxt);
  end

  always_ff @(posedge clk) begin
    alpha_r <= alpha_nxt;
    beta_r  <= beta_nxt;
  end

  // valid bits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
    end else begin
      v1_r <= in_valid;
      v2_r <= v1_r;
    end
  end

  assign out_valid = v2_r;
  assign alpha     = alpha_r;
  assign beta      = beta_r;

endmodule

>>> design/ips_sector.sv
// sector search, active times, divisor and compare numerators: five stages
// depends on ips_pkg
module ips_sector (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  input  logic signed [ips_pkg::AB_W-1:0] alpha,
  input  logic signed [ips_pkg::AB_W-1:0] beta,
  input  logic [ips_pkg::CFG_W-1:0]       supply,
  output ips_pkg::ips_side_t              side,
  output logic signed [ips_pkg::S_W-1:0]  den,
  output logic signed [ips_pkg::N_W-1:0]  num_0,
  output logic signed [ips_pkg::N_W-1:0]  num_b,
  output logic signed [ips_pkg::N_W-1:0]  num_c
);
  import ips_pkg::*;

  ips_side_t s3_r, s4_r, s5_r, s6_r, s7_r;
  ips_side_t s4_nxt;

  logic signed [KM_W-1:0] ka_r, ya_r, hb_r, bs_nxt;
  logic signed [T_W-1:0]  x_nxt, y_nxt, z_nxt, t1_nxt, t2_nxt, t1_r, t2_r;
  logic                   c1_nxt, c2_nxt;
  logic signed [S_W-1:0]  sum5_r, diff5_r, sum6_r, diff6_r, den6_r, den7_r, base_nxt, den_nxt;
  logic [CFG_W-1:0]       udc_nxt;
  logic signed [N_W-1:0]  n0_r, nb_r, nc_r;

  // stage 3: constant scaling
  always_ff @(posedge clk) begin
    ka_r <= KM_W'(alpha) * K_SQRT3;
    ya_r <= KM_W'(alpha) * K_ONE_HALF;
    hb_r <= KM_W'(beta) * K_HALF_SQRT3;
    s3_r.sector <= SEC_ZERO;
    s3_r.alpha  <= alpha;
    s3_r.beta   <= beta;
    if (!rst_n) s3_r.valid <= 1'b0;
    else s3_r.valid <= in_valid;
  end

  // stage 4: sector from three reference signs, pick active times
  always_comb begin
    bs_nxt = KM_W'(s3_r.beta) <<< SUPPLY_SH;
    c1_nxt = (ka_r - bs_nxt) > 0;
    c2_nxt = (-ka_r - bs_nxt) > 0;
    s4_nxt = s3_r;
    s4_nxt.sector = {c2_nxt, c1_nxt, s3_r.beta > 0};
    x_nxt = T_W'(hb_r) <<< 1;
    y_nxt = T_W'(ya_r) + T_W'(hb_r);
    z_nxt = T_W'(hb_r) - T_W'(ya_r);
    unique case (s4_nxt.sector)
      SEC_1: begin t1_nxt = z_nxt;  t2_nxt = y_nxt;  end
      SEC_2: begin t1_nxt = y_nxt;  t2_nxt = -x_nxt; end
      SEC_3: begin t1_nxt = -z_nxt; t2_nxt = x_nxt;  end
      SEC_4: begin t1_nxt = -x_nxt; t2_nxt = z_nxt;  end
      SEC_5: begin t1_nxt = x_nxt;  t2_nxt = -y_nxt; end
      SEC_6: begin t1_nxt = -y_nxt; t2_nxt = -z_nxt; end
      default: begin t1_nxt = '0; t2_nxt = '0; end
    endcase
  end

  always_ff @(posedge clk) begin
    t1_r <= t1_nxt;
    t2_r <= t2_nxt;
    if (!rst_n) s4_r.valid <= 1'b0;
    else s4_r <= s4_nxt;
  end

  // stage 5: sum and difference of the active times
  always_ff @(posedge clk) begin
    sum5_r  <= S_W'(t1_r) + S_W'(t2_r);
    diff5_r <= S_W'(t1_r) - S_W'(t2_r);
    if (!rst_n) s5_r.valid <= 1'b0;
    else s5_r <= s4_r;
  end

  // stage 6: divisor is the bus voltage, or the time sum when larger
  always_comb begin
    udc_nxt  = (supply == '0) ? CFG_W'(1) : supply;
    base_nxt = S_W'(udc_nxt) <<< SUPPLY_SH;
    den_nxt  = (sum5_r > base_nxt) ? sum5_r : base_nxt;
  end

  always_ff @(posedge clk) begin
    den6_r  <= den_nxt;
    sum6_r  <= sum5_r;
    diff6_r <= diff5_r;
    if (!rst_n) s6_r.valid <= 1'b0;
    else s6_r <= s5_r;
  end

  // stage 7: three compare numerators, divisor kept alongside
  always_ff @(posedge clk) begin
    n0_r   <= N_W'(den6_r) - N_W'(sum6_r);
    nb_r   <= N_W'(den6_r) + N_W'(diff6_r);
    nc_r   <= N_W'(den6_r) + N_W'(sum6_r);
    den7_r <= den6_r;
    if (!rst_n) s7_r.valid <= 1'b0;
    else s7_r <= s6_r;
  end

  assign side  = s7_r;
  assign den   = den7_r;
  assign num_0 = n0_r;
  assign num_b = nb_r;
  assign num_c = nc_r;

endmodule

>>> design/ips_div.sv
// pipelined restoring divider, one quotient bit per stage
// depends on ips_pkg
module ips_div (
  input  logic                        clk,
  input  logic [ips_pkg::DIV_W-1:0]   dividend,
  input  logic [ips_pkg::DIV_W-1:0]   divisor,
  output logic [ips_pkg::Q_W-1:0]     quotient
);
  import ips_pkg::*;

  logic [DIV_W-1:0] rem_r [DIV_STAGES];
  logic [DIV_W-1:0] dvs_r [DIV_STAGES];
  logic [Q_W-1:0]   q_r   [DIV_STAGES];

  for (genvar i = 0; i < DIV_STAGES; i++) begin : g_stage
    localparam int SH = DIV_STAGES - 1 - i;
    logic [DIV_W-1:0] rem_prev, dvs_prev, trial_nxt;
    logic [Q_W-1:0]   q_prev;
    logic             ge_nxt;

    if (i == 0) begin : g_first
      assign rem_prev = dividend;
      assign dvs_prev = divisor;
      assign q_prev   = '0;
    end else begin : g_next
      assign rem_prev = rem_r[i-1];
      assign dvs_prev = dvs_r[i-1];
      assign q_prev   = q_r[i-1];
    end

    // trial subtract of the shifted divisor
    assign trial_nxt = dvs_prev << SH;
    assign ge_nxt    = rem_prev >= trial_nxt;

    always_ff @(posedge clk) begin
      rem_r[i] <= ge_nxt ? (rem_prev - trial_nxt) : rem_prev;
      dvs_r[i] <= dvs_prev;
      q_r[i]   <= q_prev | (Q_W'(ge_nxt) << SH);
    end
  end

  assign quotient = q_r[DIV_STAGES-1];

endmodule

>>> verif/tb_top.sv
// self-checking testbench for inverse_park_svpwm: inverse park rotation and svpwm compares
// depends on ips_pkg and the inverse_park_svpwm rtl; holds its own bit-exact predictor
`timescale 1ns / 100ps

module tb_top;
  import ips_pkg::*;

  localparam int  PIPE_DRAIN  = 40;
  localparam longint CYCLE_LIMIT = 600000;
  localparam longint HALF_SQRT3 = 56756;
  localparam longint ONE_HALF   = 98304;

  typedef struct packed {
    logic signed [AB_W-1:0] alpha;
    logic signed [AB_W-1:0] beta;
    logic [CMP_W-1:0]       cmp_a;
    logic [CMP_W-1:0]       cmp_b;
    logic [CMP_W-1:0]       cmp_c;
  } pwm_beat_t;

  logic                    clk;
  logic                    rst_n;
  logic                    start;
  logic                    busy;
  logic signed [IN_W-1:0]  in_volt_q;
  logic signed [IN_W-1:0]  in_volt_d;
  logic signed [IN_W-1:0]  in_sin_angle;
  logic signed [IN_W-1:0]  in_cos_angle;
  logic                    cfg_wr_en;
  logic [CFG_IDX_W-1:0]    cfg_index;
  logic [CFG_W-1:0]        cfg_wdata;
  logic                    out_valid;
  logic signed [AB_W-1:0]  out_volt_alpha;
  logic signed [AB_W-1:0]  out_volt_beta;
  logic [CMP_W-1:0]        out_compare_a;
  logic [CMP_W-1:0]        out_compare_b;
  logic [CMP_W-1:0]        out_compare_c;

  // shadow copy of the configuration registers
  logic [CFG_W-1:0] bus_volt;
  logic [CFG_W-1:0] period_cnt;

  pwm_beat_t pending_pwm[$];
  int        mismatches;
  longint    cycle_cnt;

  inverse_park_svpwm DUT (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .in_volt_q(in_volt_q), .in_volt_d(in_volt_d),
    .in_sin_angle(in_sin_angle), .in_cos_angle(in_cos_angle),
    .cfg_wr_en(cfg_wr_en), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata),
    .out_valid(out_valid), .out_volt_alpha(out_volt_alpha), .out_volt_beta(out_volt_beta),
    .out_compare_a(out_compare_a), .out_compare_b(out_compare_b),
    .out_compare_c(out_compare_c)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // rounding half up from q(f+14) to qf with 17 bit saturation
  function automatic longint rot_round(longint s);
    longint r;
    r = (s + 8192) >>> 14;
    if (r > 65535) r = 65535;
    if (r < -65536) r = -65536;
    return r;
  endfunction

  function automatic longint duty_count(longint num, longint den, longint lim);
    longint v;
    if (num < 0) return 0;
    v = (num + 2 * den) / (4 * den);
    if (v > lim) v = lim;
    return v;
  endfunction

  // expected alpha/beta and phase compares for one command beat
  function automatic pwm_beat_t svpwm_predict(logic signed [IN_W-1:0] vq,
                                              logic signed [IN_W-1:0] vd,
                                              logic signed [IN_W-1:0] sn,
                                              logic signed [IN_W-1:0] cs);
    pwm_beat_t r;
    longint a, b, arr, udc, lim, xs, ys, zs, t1, t2, den, v0, vb, vc;
    logic [2:0] sec;
    a = rot_round(longint'(vd) * longint'(cs) - longint'(vq) * longint'(sn));
    b = rot_round(longint'(vd) * longint'(sn) + longint'(vq) * longint'(cs));
    arr = longint'(period_cnt);
    udc = (bus_volt == 0) ? 1 : longint'(bus_volt);
    lim = (arr >= 5) ? arr - 5 : 0;
    sec = SEC_ZERO;
    if (b > 0) sec = sec + 3'd1;
    if (2 * HALF_SQRT3 * a - 65536 * b > 0) sec = sec + 3'd2;
    if (-2 * HALF_SQRT3 * a - 65536 * b > 0) sec = sec + 3'd4;
    xs = 2 * HALF_SQRT3 * b;
    ys = ONE_HALF * a + HALF_SQRT3 * b;
    zs = -ONE_HALF * a + HALF_SQRT3 * b;
    t1 = 0;
    t2 = 0;
    case (sec)
      SEC_1: begin t1 = zs;  t2 = ys;  end
      SEC_2: begin t1 = ys;  t2 = -xs; end
      SEC_3: begin t1 = -zs; t2 = xs;  end
      SEC_4: begin t1 = -xs; t2 = zs;  end
      SEC_5: begin t1 = xs;  t2 = -ys; end
      SEC_6: begin t1 = -ys; t2 = -zs; end
      default: ;
    endcase
    r.alpha = a[AB_W-1:0];
    r.beta  = b[AB_W-1:0];
    r.cmp_a = '0;
    r.cmp_b = '0;
    r.cmp_c = '0;
    if (sec != SEC_ZERO && sec <= SEC_6) begin
      den = udc * 65536;
      if (t1 + t2 > den) den = t1 + t2;
      v0 = duty_count(arr * (den - t1 - t2), den, lim);
      vb = duty_count(arr * (den + t1 - t2), den, lim);
      vc = duty_count(arr * (den + t1 + t2), den, lim);
      case (sec)
        SEC_1: begin r.cmp_a = CMP_W'(vb); r.cmp_b = CMP_W'(v0); r.cmp_c = CMP_W'(vc); end
        SEC_2: begin r.cmp_a = CMP_W'(v0); r.cmp_b = CMP_W'(vc); r.cmp_c = CMP_W'(vb); end
        SEC_3: begin r.cmp_a = CMP_W'(v0); r.cmp_b = CMP_W'(vb); r.cmp_c = CMP_W'(vc); end
        SEC_4: begin r.cmp_a = CMP_W'(vc); r.cmp_b = CMP_W'(vb); r.cmp_c = CMP_W'(v0); end
        SEC_5: begin r.cmp_a = CMP_W'(vc); r.cmp_b = CMP_W'(v0); r.cmp_c = CMP_W'(vb); end
        default: begin r.cmp_a = CMP_W'(vb); r.cmp_b = CMP_W'(vc); r.cmp_c = CMP_W'(v0); end
      endcase
    end
    return r;
  endfunction

  // mostly short gaps, a few long ones
  function automatic int pick_gap();
    int p;
    p = $urandom_range(99);
    if (p < 50) return 0;
    if (p < 85) return $urandom_range(3, 1);
    if (p < 98) return $urandom_range(10, 4);
    return $urandom_range(60, 20);
  endfunction

  // send one command beat and wait for it to be taken
  task automatic send_beat(logic signed [IN_W-1:0] vq, logic signed [IN_W-1:0] vd,
                           logic signed [IN_W-1:0] sn, logic signed [IN_W-1:0] cs);
    logic was_busy;
    int gap;
    start        <= 1'b1;
    in_volt_q    <= vq;
    in_volt_d    <= vd;
    in_sin_angle <= sn;
    in_cos_angle <= cs;
    do begin
      @(negedge clk);
      was_busy = busy;
      @(posedge clk);
    end while (was_busy);
    pending_pwm.push_back(svpwm_predict(vq, vd, sn, cs));
    gap = pick_gap();
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // let every beat in flight come out
  task automatic wait_drained();
    start <= 1'b0;
    while (pending_pwm.size() != 0) @(posedge clk);
    repeat (PIPE_DRAIN) @(posedge clk);
  endtask

  task automatic set_config(logic [CFG_W-1:0] supply, logic [CFG_W-1:0] period);
    cfg_wr_en <= 1'b1;
    cfg_index <= REG_SUPPLY;
    cfg_wdata <= supply;
    @(posedge clk);
    cfg_index <= REG_PERIOD;
    cfg_wdata <= period;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    bus_volt   = supply;
    period_cnt = period;
    @(posedge clk);
  endtask

  // rotation by a random angle with random dq magnitudes, or raw noise
  task automatic send_random();
    real th;
    logic signed [IN_W-1:0] sn, cs, vq, vd;
    int p;
    p = $urandom_range(99);
    th = $urandom_range(36000) * 3.14159265358979 / 18000.0;
    sn = IN_W'($rtoi($sin(th) * 16384.0));
    cs = IN_W'($rtoi($cos(th) * 16384.0));
    if (p < 60) begin
      vq = $signed(16'($urandom_range(24000))) - 16'sd12000;
      vd = $signed(16'($urandom_range(8000))) - 16'sd4000;
    end else if (p < 85) begin
      vq = IN_W'($urandom);
      vd = IN_W'($urandom);
    end else begin
      vq = IN_W'($urandom);
      vd = IN_W'($urandom);
      sn = IN_W'($urandom);
      cs = IN_W'($urandom);
    end
    send_beat(vq, vd, sn, cs);
  endtask

  // zero vector, field extremes, each sector, out-of-range sine/cosine
  task automatic test_directed();
    int k;
    real th;
    send_beat(16'sd0, 16'sd0, 16'sd0, 16'sd16384);
    send_beat(16'sd0, 16'sd0, 16'sd11585, 16'sd11585);
    send_beat(16'sd32767, 16'sd0, 16'sd0, 16'sd16384);
    send_beat(-16'sd32768, 16'sd0, 16'sd0, 16'sd16384);
    send_beat(16'sd32767, 16'sd32767, 16'sd16384, 16'sd16384);
    send_beat(-16'sd32768, -16'sd32768, -16'sd16384, -16'sd16384);
    send_beat(-16'sd32768, 16'sd32767, -16'sd32768, 16'sd32767);
    send_beat(16'sd32767, -16'sd32768, 16'sd32767, -16'sd32768);
    send_beat(16'sd1, 16'sd0, 16'sd0, 16'sd16384);
    send_beat(16'sd0, -16'sd1, 16'sd0, 16'sd16384);
    for (k = 0; k < 12; k++) begin
      th = (30.0 * k + 15.0) * 3.14159265358979 / 180.0;
      send_beat(16'sd2048, 16'sd0, IN_W'($rtoi($sin(th) * 16384.0)),
                IN_W'($rtoi($cos(th) * 16384.0)));
    end
    send_beat(16'sd20000, 16'sd0, 16'sd16384, 16'sd0);
    wait_drained();
  endtask

  task automatic test_random(int count);
    int k;
    for (k = 0; k < count; k++) send_random();
    wait_drained();
  endtask

  // sender holds off until the pipeline has emptied mid-stream
  task automatic test_hold_off();
    int k;
    for (k = 0; k < 20; k++) send_random();
    wait_drained();
    for (k = 0; k < 20; k++) send_random();
    wait_drained();
  endtask

  // result checker
  always @(posedge clk) begin
    pwm_beat_t exp_beat;
    if (rst_n && out_valid) begin
      if (pending_pwm.size() == 0) begin
        mismatches <= mismatches + 1;
        if (mismatches < 10) $display("unexpected result beat alpha=%0d", out_volt_alpha);
      end else begin
        exp_beat = pending_pwm.pop_front();
        if (exp_beat.alpha !== out_volt_alpha || exp_beat.beta !== out_volt_beta ||
            exp_beat.cmp_a !== out_compare_a || exp_beat.cmp_b !== out_compare_b ||
            exp_beat.cmp_c !== out_compare_c) begin
          mismatches <= mismatches + 1;
          if (mismatches < 10)
            $display("mismatch exp a=%0d b=%0d c=%0d/%0d/%0d got a=%0d b=%0d c=%0d/%0d/%0d",
                     exp_beat.alpha, exp_beat.beta, exp_beat.cmp_a, exp_beat.cmp_b,
                     exp_beat.cmp_c, out_volt_alpha, out_volt_beta, out_compare_a,
                     out_compare_b, out_compare_c);
        end
      end
    end
  end

  // run limit
  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt > CYCLE_LIMIT) begin
      $display("[inverse_park_svpwm] ERROR");
      $finish;
    end
  end

  initial begin
    mismatches   = 0;
    cycle_cnt    = 0;
    rst_n        = 1'b0;
    start        = 1'b0;
    in_volt_q    = '0;
    in_volt_d    = '0;
    in_sin_angle = '0;
    in_cos_angle = '0;
    cfg_wr_en    = 1'b0;
    cfg_index    = REG_SUPPLY;
    cfg_wdata    = '0;
    bus_volt     = SUPPLY_RESET;
    period_cnt   = PERIOD_RESET;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_directed();
    test_random(250);
    test_hold_off();
    set_config(16'd1, 16'd65535);
    test_directed();
    test_random(120);
    set_config(16'd65535, 16'd6);
    test_random(100);
    set_config(16'd0, 16'd0);
    test_random(60);
    set_config(16'd2000, 16'd3);
    test_random(60);
    set_config(16'd5000, 16'd100);
    test_random(100);
    set_config(16'($urandom), 16'($urandom));
    test_random(100);
    set_config(SUPPLY_RESET, PERIOD_RESET);
    test_random(60);

    if (mismatches == 0 && pending_pwm.size() == 0) begin
      $display("[inverse_park_svpwm] OK");
    end else begin
      $display("[inverse_park_svpwm] ERROR");
    end
    $finish;
  end

endmodule
